/* hw/rtl/pu_pkg.sv */
// Shared types, widths and constant tables for the permutation unranking block.
// No dependencies; every other file of the block imports it.
package pu_pkg;

    localparam int SIZE_W     = 4;   // set size field
    localparam int RANK_W     = 19;  // rank field
    localparam int ELEM_W     = 4;   // element value field
    localparam int POS_W      = 4;   // position field
    localparam int FACT_W     = 32;  // wide enough for 12!
    localparam int FACT_LIMIT = 12;  // largest set size the tables cover

    // Job handed from the front end to the back end through the queue.
    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [RANK_W-1:0] rank0;    // zero-based rank
        logic              err;      // set size or rank out of range
    } t_job;

    // q * m! for m and q in 0..FACT_LIMIT-1, indexed [m][q].
    typedef logic [FACT_LIMIT-1:0][FACT_LIMIT-1:0][FACT_W-1:0] t_mul_tab;

    function automatic logic [FACT_W-1:0] fact_of(input logic [SIZE_W-1:0] m);
        logic [FACT_W-1:0] f;
        case (m)
            4'd0:    f = 32'd1;
            4'd1:    f = 32'd1;
            4'd2:    f = 32'd2;
            4'd3:    f = 32'd6;
            4'd4:    f = 32'd24;
            4'd5:    f = 32'd120;
            4'd6:    f = 32'd720;
            4'd7:    f = 32'd5040;
            4'd8:    f = 32'd40320;
            4'd9:    f = 32'd362880;
            4'd10:   f = 32'd3628800;
            4'd11:   f = 32'd39916800;
            4'd12:   f = 32'd479001600;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic t_mul_tab build_mul_tab();
        t_mul_tab t;
        for (int m = 0; m < FACT_LIMIT; m++) begin
            for (int q = 0; q < FACT_LIMIT; q++) begin
                t[m][q] = FACT_W'(q) * fact_of(SIZE_W'(m));
            end
        end
        return t;
    endfunction

    // Digit thresholds, folded to constants at elaboration.
    localparam t_mul_tab MUL_TAB = build_mul_tab();

endpackage

/* hw/rtl/pu_if.sv */
// Valid/ready channel interfaces for the request and result streams.
// Depends on pu_pkg for the field widths.
interface pu_in_if;
    import pu_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] set_size;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output set_size, output rank, input ready);
    modport sink   (input valid, input set_size, input rank, output ready);
endinterface

interface pu_out_if;
    import pu_pkg::*;
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic              last;
    logic              error;

    modport source (output valid, output element, output position, output last,
                    output error, input ready);
    modport sink   (input valid, input element, input position, input last,
                    input error, output ready);
endinterface

/* hw/rtl/pu_front.sv */
// Front end: range checks on each request beat and packing into a job.
// Depends on pu_pkg and pu_in_if.
module pu_front import pu_pkg::*; #(
    parameter int MAX_N = 9
) (
    pu_in_if.sink i_in,
    output logic  o_job_valid,
    output t_job  o_job,
    input  logic  i_job_ready
);

    logic size_ok;
    logic rank_ok;

    always_comb begin
        size_ok = (i_in.set_size != '0) && (i_in.set_size <= SIZE_W'(MAX_N));
        rank_ok = (i_in.rank != '0) &&
                  (FACT_W'(i_in.rank) <= fact_of(i_in.set_size));
    end

    assign o_job_valid    = i_in.valid;
    assign i_in.ready     = i_job_ready;
    assign o_job.set_size = i_in.set_size;
    assign o_job.rank0    = i_in.rank - RANK_W'(1);
    assign o_job.err      = !(size_ok && rank_ok);

endmodule

/* hw/rtl/pu_queue.sv */
// Two-entry job queue between front and back ends.
// Depends on pu_pkg.
module pu_queue import pu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop_ready
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_job;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("job queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wptr != r_rptr))
        else $error("job queue pointers disagree with count");
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd1) |-> (r_wptr == r_rptr))
        else $error("job queue pointers disagree with count");
`endif

endmodule

/* hw/rtl/pu_back.sv */
// Back end: factorial-base digit extraction with a value pool and a result
// register, one element per cycle unless stalled. Depends on pu_pkg and pu_out_if.
module pu_back import pu_pkg::*; #(
    parameter int MAX_N = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_ready,
    pu_out_if.source   o_res
);

    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state            r_state, n_state;
    logic [ELEM_W-1:0] r_pool [MAX_N];
    logic [ELEM_W-1:0] n_pool [MAX_N];
    logic [RANK_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_len, n_len;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_out_valid, n_out_valid;
    logic [ELEM_W-1:0] r_element, n_element;
    logic [POS_W-1:0]  r_position, n_position;
    logic              r_last, n_last;
    logic              r_error, n_error;

    logic              out_free;
    logic              pop;
    logic [SIZE_W-1:0] m;
    logic [SIZE_W-1:0] avail;
    logic [IDX_W-1:0]  idx;
    logic [FACT_W-1:0] sub;
    logic              at_last;

    assign out_free    = !r_out_valid || o_res.ready;
    assign pop         = (r_state == ST_IDLE) && i_job_valid && out_free;
    assign o_job_ready = pop;

    // Digit = number of multiples q*m! not above the remaining rank.
    always_comb begin
        avail = r_len - SIZE_W'(r_pos);
        m     = avail - SIZE_W'(1);
        idx   = '0;
        sub   = '0;
        for (int q = 1; q < MAX_N; q++) begin
            if ((SIZE_W'(q) < avail) && (FACT_W'(r_rem) >= MUL_TAB[m][q])) begin
                idx = IDX_W'(q);
                sub = MUL_TAB[m][q];
            end
        end
        at_last = (r_pos == POS_W'(r_len - SIZE_W'(1)));
    end

    always_comb begin
        n_state     = r_state;
        n_pool      = r_pool;
        n_rem       = r_rem;
        n_len       = r_len;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        n_element   = r_element;
        n_position  = r_position;
        n_last      = r_last;
        n_error     = r_error;
        case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    if (i_job.err) begin
                        n_out_valid = 1'b1;
                        n_element   = '0;
                        n_position  = '0;
                        n_last      = 1'b1;
                        n_error     = 1'b1;
                    end else begin
                        for (int j = 0; j < MAX_N; j++) begin
                            n_pool[j] = ELEM_W'(j + 1);
                        end
                        n_rem   = i_job.rank0;
                        n_len   = i_job.set_size;
                        n_pos   = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = r_pool[idx];
                    n_position  = r_pos;
                    n_last      = at_last;
                    n_error     = 1'b0;
                    for (int j = 0; j < MAX_N - 1; j++) begin
                        if (IDX_W'(j) >= idx) begin
                            n_pool[j] = r_pool[j + 1];
                        end
                    end
                    n_rem = RANK_W'(FACT_W'(r_rem) - sub);
                    n_pos = r_pos + POS_W'(1);
                    if (at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pool     <= n_pool;
        r_rem      <= n_rem;
        r_len      <= n_len;
        r_pos      <= n_pos;
        r_element  <= n_element;
        r_position <= n_position;
        r_last     <= n_last;
        r_error    <= n_error;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.element  = r_element;
    assign o_res.position = r_position;
    assign o_res.last     = r_last;
    assign o_res.error    = r_error;

`ifndef ASSERT_OFF
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pos < POS_W'(r_len)))
        else $error("position counter ran past set size");
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error) |-> (r_last && (r_element == '0)))
        else $error("error result not a lone final beat");
    a_elem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_error) |-> (r_element != '0))
        else $error("normal result carries an empty pool entry");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> ((r_state == ST_IDLE) && i_job_valid))
        else $error("job taken while busy");
`endif

endmodule

/* hw/rtl/permutation_unrank.sv */
// Top level of the k-th permutation unranking block.
// Depends on pu_pkg, pu_if, pu_front, pu_queue and pu_back.
//
// Each request beat carries a set size n and a one-based rank k; the block
// returns the k-th permutation of 1..n in lexicographic order as n result
// beats, one element per beat in position order, with last set on the
// final one. A request with n outside 1..MAX_N, or k outside 1..n!, gives
// a single beat with error and last set and element and position zero.
// The front end range-checks each request and hands it to a two-entry job
// queue, so up to two further requests are taken while the back end works.
// The back end takes a job only while idle, computes its elements in the run
// state and takes no new job until the last; an error request is answered
// from the idle state alone. Each element step compares the remaining rank
// with the constant multiples q*m! of the remaining factorial, takes the digit
// as index into the ascending pool of unused values, closes the gap in the
// pool and subtracts; this compare-and-subtract path sets the pace. The result
// register lets the next element be computed in the cycle the previous one is
// taken, so backpressure costs no more than the stall. There is no
// configuration; reset clears the queue count and pointers, state and valid.
module permutation_unrank import pu_pkg::*; #(
    parameter int MAX_N = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pu_in_if.sink     i_in,
    pu_out_if.source  o_res
);

    // Front end to queue
    logic f_job_valid;
    t_job f_job;
    logic f_job_ready;
    // Queue to back end
    logic q_job_valid;
    t_job q_job;
    logic q_job_ready;

    pu_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .i_in        (i_in),
        .o_job_valid (f_job_valid),
        .o_job       (f_job),
        .i_job_ready (f_job_ready)
    );

    pu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_job_valid),
        .i_push_job   (f_job),
        .o_push_ready (f_job_ready),
        .o_pop_valid  (q_job_valid),
        .o_pop_job    (q_job),
        .i_pop_ready  (q_job_ready)
    );

    pu_back #(
        .MAX_N (MAX_N)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_job_valid),
        .i_job       (q_job),
        .o_job_ready (q_job_ready),
        .o_res       (o_res)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for permutation_unrank: random and directed requests,
// predicted permutations checked beat by beat. Depends on pu_pkg and pu_if.
module tb_top;
    import pu_pkg::*;

    localparam int MAX_N        = 9;
    localparam int RANDOM_REQS  = 310;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [RANK_W-1:0] rank;
    } t_perm_req;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [POS_W-1:0]  position;
        logic              last;
        logic              error;
    } t_perm_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pu_in_if  req_if ();
    pu_out_if res_if ();

    permutation_unrank #(
        .MAX_N (MAX_N)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_res   (res_if)
    );

    t_perm_req  pending_reqs [$];
    t_perm_beat perm_exp [$];
    t_perm_req  next_req;
    t_perm_beat got_beat;
    t_perm_beat want_beat;

    int  total_reqs = 0;
    int  req_beats  = 0;
    int  hold_cnt   = 0;
    bit  hold_done  = 1'b0;
    int  err_cnt    = 0;
    int  cycle_cnt  = 0;
    logic calm;

    // no idling on either side over this window of requests
    assign calm = (req_beats >= 180) && (req_beats < 260);

    always #6 i_clk = ~i_clk;

    function automatic int unsigned factorial(input int m);
        int unsigned f;
        f = 1;
        for (int i = 2; i <= m; i++) f = f * i;
        return f;
    endfunction

    // Expected beats of one request: digits of the zero-based rank in the
    // factorial base pick entries from the ascending pool of unused values.
    function automatic void predict_perm(input logic [SIZE_W-1:0] n,
                                         input logic [RANK_W-1:0] k);
        logic [ELEM_W-1:0] pool [0:15];
        int unsigned       left;
        int unsigned       f;
        int unsigned       digit;
        int unsigned       avail;
        t_perm_beat        b;
        if (n == 0 || n > MAX_N || k == 0 || k > factorial(n)) begin
            b = '{element: '0, position: '0, last: 1'b1, error: 1'b1};
            perm_exp.push_back(b);
            return;
        end
        for (int i = 0; i < n; i++) pool[i] = ELEM_W'(i + 1);
        left = k - 1;
        for (int i = 0; i < n; i++) begin
            f     = factorial(n - 1 - i);
            digit = left / f;
            avail = n - i;
            if (digit >= avail) digit = avail - 1;
            b.element  = pool[digit];
            b.position = POS_W'(i);
            b.last     = (i == n - 1);
            b.error    = 1'b0;
            perm_exp.push_back(b);
            for (int j = digit; j + 1 < avail; j++) pool[j] = pool[j + 1];
            left = left % f;
        end
    endfunction

    task automatic add_req(input int n, input int k);
        t_perm_req r;
        r.set_size = SIZE_W'(n);
        r.rank     = RANK_W'(k);
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // request driver: a beat stays offered until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_beats    <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_perm(req_if.set_size, req_if.rank);
                req_beats <= req_beats + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 &&
                    (calm || hold_cnt != 0 || $urandom_range(99) >= 12)) begin
                    next_req         = pending_reqs.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.set_size <= next_req.set_size;
                    req_if.rank     <= next_req.rank;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so the job queue fills and stalls requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && req_beats >= 40) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got_beat = '{element: res_if.element, position: res_if.position,
                             last: res_if.last, error: res_if.error};
                if (perm_exp.size() == 0) begin
                    report($sformatf("unexpected beat elem %0d pos %0d last %0b err %0b",
                                     got_beat.element, got_beat.position,
                                     got_beat.last, got_beat.error));
                end else begin
                    want_beat = perm_exp.pop_front();
                    if (got_beat.element  !== want_beat.element  ||
                        got_beat.position !== want_beat.position ||
                        got_beat.last     !== want_beat.last     ||
                        got_beat.error    !== want_beat.error) begin
                        report($sformatf({"got elem %0d pos %0d last %0b err %0b, ",
                                          "want elem %0d pos %0d last %0b err %0b"},
                                         got_beat.element, got_beat.position,
                                         got_beat.last, got_beat.error,
                                         want_beat.element, want_beat.position,
                                         want_beat.last, want_beat.error));
                    end
                end
            end
            res_if.ready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int sel;
        int n;
        int k;
        req_if.valid    = 1'b0;
        req_if.set_size = '0;
        req_if.rank     = '0;
        res_if.ready    = 1'b0;

        // directed: edges of both fields and each out-of-range case
        add_req(1, 1);
        add_req(1, 2);            // rank above 1!
        add_req(0, 1);            // set size zero
        add_req(0, 0);
        add_req(10, 1);           // set size above MAX_N
        add_req(15, 524287);      // all ones in both fields
        add_req(9, 1);            // identity
        add_req(9, 362880);       // fully reversed
        add_req(9, 362881);       // rank one past 9!
        add_req(9, 0);            // rank zero
        add_req(9, 524287);
        add_req(2, 1);
        add_req(2, 2);
        add_req(3, 4);
        add_req(4, 24);
        add_req(4, 25);
        add_req(8, 40320);
        add_req(8, 12345);
        add_req(5, 121);
        add_req(7, 5040);
        add_req(6, 1);

        // random: mostly well-formed, the rest out of range in either field
        for (int i = 0; i < RANDOM_REQS; i++) begin
            sel = $urandom_range(99);
            n   = $urandom_range(1, MAX_N);
            if (sel < 82) begin
                k = $urandom_range(1, factorial(n));
            end else if (sel < 88) begin
                n = $urandom_range(0, 6);
                if (n != 0) n = n + MAX_N;
                k = $urandom_range(0, 2**RANK_W - 1);
            end else if (sel < 94) begin
                k = 0;
            end else begin
                k = $urandom_range(factorial(n) + 1, 2**RANK_W - 1);
            end
            add_req(n, k);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_beats != total_reqs) @(posedge i_clk);
        while (perm_exp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pu_pkg.sv
hw/rtl/pu_if.sv
hw/rtl/pu_front.sv
hw/rtl/pu_queue.sv
hw/rtl/pu_back.sv
hw/rtl/permutation_unrank.sv
tb/tb_top.sv
